### sv/rpt_alarm_pkg.sv
// Shared types, codes and digit helper functions for the repeating alarm block.
package rpt_alarm_pkg;

  localparam logic [1:0] ACT_CHECK = 2'd0;
  localparam logic [1:0] ACT_UP    = 2'd1;
  localparam logic [1:0] ACT_DOWN  = 2'd2;

  localparam logic [3:0] POS_HOUR_TENS  = 4'd3;
  localparam logic [3:0] POS_HOUR_UNITS = 4'd4;
  localparam logic [3:0] POS_MIN_TENS   = 4'd6;
  localparam logic [3:0] POS_MIN_UNITS  = 4'd7;
  localparam logic [3:0] POS_REP_TENS   = 4'd9;
  localparam logic [3:0] POS_REP_UNITS  = 4'd10;
  localparam logic [3:0] POS_INT_TENS   = 4'd13;
  localparam logic [3:0] POS_INT_UNITS  = 4'd14;

  localparam logic [10:0] MINUTES_PER_HOUR = 11'd60;
  localparam logic [10:0] MINUTES_PER_DAY  = 11'd1440;
  localparam logic [4:0]  HOUR_MAX         = 5'd23;
  localparam logic [5:0]  MINUTE_MAX       = 6'd59;
  localparam logic [3:0]  MIN_TOP_TENS     = 4'd5;
  localparam logic [3:0]  DEC_TOP_TENS     = 4'd9;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [6:0] repeats;
    logic [6:0] interval;
  } alarm_set_t;

  typedef struct packed {
    logic       start;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
  } scan_ctl_t;

  typedef struct packed {
    logic done;
    logic found;
  } scan_sts_t;

  // Tens digit of a value below 128, by multiplication with a reciprocal.
  function automatic logic [3:0] div10(input logic [6:0] v);
    logic [17:0] p;
    p = 18'(v) * 18'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] units_of(input logic [6:0] v);
    logic [6:0] t10;
    t10 = 7'(div10(v)) * 7'd10;
    return 4'(v - t10);
  endfunction

  function automatic logic [6:0] tens_up(input logic [6:0] v, input logic [3:0] top);
    logic [6:0] sub;
    sub = 7'(top) * 7'd10;
    return (div10(v) >= top) ? 7'(v - sub) : 7'(v + 7'd10);
  endfunction

  function automatic logic [6:0] tens_down(input logic [6:0] v, input logic [3:0] top);
    logic [6:0] add;
    add = 7'(top) * 7'd10;
    return (v < 7'd10) ? 7'(v + add) : 7'(v - 7'd10);
  endfunction

  function automatic logic [6:0] units_up(input logic [6:0] v);
    return (units_of(v) == 4'd9) ? 7'(v - 7'd9) : 7'(v + 7'd1);
  endfunction

  function automatic logic [6:0] units_down(input logic [6:0] v);
    return (units_of(v) == 4'd0) ? 7'(v + 7'd9) : 7'(v - 7'd1);
  endfunction

endpackage

### sv/rpt_alarm_edit.sv
// Decimal digit editor that steps one digit of the alarm settings up or down.
module rpt_alarm_edit (
  input  logic [1:0]               action,
  input  logic [3:0]               digit_pos,
  input  rpt_alarm_pkg::alarm_set_t set_cur,
  output rpt_alarm_pkg::alarm_set_t set_nxt
);

  logic [6:0] hour7;

  assign hour7 = 7'(set_cur.hour);

  always_comb begin
    set_nxt = set_cur;
    if (action == rpt_alarm_pkg::ACT_UP) begin
      unique case (digit_pos)
        rpt_alarm_pkg::POS_HOUR_TENS: begin
          if (set_cur.hour >= 5'd20) begin
            set_nxt.hour = 5'(set_cur.hour - 5'd20);
          end else if (set_cur.hour > 5'd13) begin
            set_nxt.hour = 5'(set_cur.hour - 5'd10);
          end else begin
            set_nxt.hour = 5'(set_cur.hour + 5'd10);
          end
        end
        rpt_alarm_pkg::POS_HOUR_UNITS: begin
          set_nxt.hour = (set_cur.hour == rpt_alarm_pkg::HOUR_MAX) ? 5'd20 :
                         5'(rpt_alarm_pkg::units_up(hour7));
        end
        rpt_alarm_pkg::POS_MIN_TENS: begin
          set_nxt.minute = 6'(rpt_alarm_pkg::tens_up(7'(set_cur.minute),
                                                     rpt_alarm_pkg::MIN_TOP_TENS));
        end
        rpt_alarm_pkg::POS_MIN_UNITS: begin
          set_nxt.minute = 6'(rpt_alarm_pkg::units_up(7'(set_cur.minute)));
        end
        rpt_alarm_pkg::POS_REP_TENS: begin
          set_nxt.repeats = rpt_alarm_pkg::tens_up(set_cur.repeats,
                                                   rpt_alarm_pkg::DEC_TOP_TENS);
        end
        rpt_alarm_pkg::POS_REP_UNITS: begin
          set_nxt.repeats = rpt_alarm_pkg::units_up(set_cur.repeats);
        end
        rpt_alarm_pkg::POS_INT_TENS: begin
          set_nxt.interval = rpt_alarm_pkg::tens_up(set_cur.interval,
                                                    rpt_alarm_pkg::DEC_TOP_TENS);
        end
        rpt_alarm_pkg::POS_INT_UNITS: begin
          set_nxt.interval = rpt_alarm_pkg::units_up(set_cur.interval);
        end
        default: begin
          set_nxt = set_cur;
        end
      endcase
    end else if (action == rpt_alarm_pkg::ACT_DOWN) begin
      unique case (digit_pos)
        rpt_alarm_pkg::POS_HOUR_TENS: begin
          if (set_cur.hour < 5'd4) begin
            set_nxt.hour = 5'(set_cur.hour + 5'd20);
          end else if (set_cur.hour < 5'd10) begin
            set_nxt.hour = 5'(set_cur.hour + 5'd10);
          end else begin
            set_nxt.hour = 5'(set_cur.hour - 5'd10);
          end
        end
        rpt_alarm_pkg::POS_HOUR_UNITS: begin
          set_nxt.hour = (set_cur.hour == 5'd20) ? rpt_alarm_pkg::HOUR_MAX :
                         5'(rpt_alarm_pkg::units_down(hour7));
        end
        rpt_alarm_pkg::POS_MIN_TENS: begin
          set_nxt.minute = 6'(rpt_alarm_pkg::tens_down(7'(set_cur.minute),
                                                       rpt_alarm_pkg::MIN_TOP_TENS));
        end
        rpt_alarm_pkg::POS_MIN_UNITS: begin
          set_nxt.minute = 6'(rpt_alarm_pkg::units_down(7'(set_cur.minute)));
        end
        rpt_alarm_pkg::POS_REP_TENS: begin
          set_nxt.repeats = rpt_alarm_pkg::tens_down(set_cur.repeats,
                                                     rpt_alarm_pkg::DEC_TOP_TENS);
        end
        rpt_alarm_pkg::POS_REP_UNITS: begin
          set_nxt.repeats = rpt_alarm_pkg::units_down(set_cur.repeats);
        end
        rpt_alarm_pkg::POS_INT_TENS: begin
          set_nxt.interval = rpt_alarm_pkg::tens_down(set_cur.interval,
                                                      rpt_alarm_pkg::DEC_TOP_TENS);
        end
        rpt_alarm_pkg::POS_INT_UNITS: begin
          set_nxt.interval = rpt_alarm_pkg::units_down(set_cur.interval);
        end
        default: begin
          set_nxt = set_cur;
        end
      endcase
    end
  end

endmodule

### sv/rpt_alarm_scan.sv
// Repetition scanner: one shared add-and-wrap step and one compare per cycle.
module rpt_alarm_scan (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rpt_alarm_pkg::scan_ctl_t  ctl,
  input  rpt_alarm_pkg::alarm_set_t set_cur,
  output rpt_alarm_pkg::scan_sts_t  sts
);

  logic        busy_r,   busy_nxt;
  logic        done_r,   done_nxt;
  logic        found_r,  found_nxt;
  logic        now_ok_r, now_ok_nxt;
  logic [10:0] t_r,      t_nxt;
  logic [10:0] now_r,    now_nxt;
  logic [6:0]  cnt_r,    cnt_nxt;
  logic [11:0] t_sum;

  assign t_sum = 12'(t_r) + 12'(set_cur.interval);

  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    found_nxt  = found_r;
    now_ok_nxt = now_ok_r;
    t_nxt      = t_r;
    now_nxt    = now_r;
    cnt_nxt    = cnt_r;
    if (ctl.start) begin
      busy_nxt   = 1'b1;
      cnt_nxt    = 7'd0;
      t_nxt      = 11'(11'(set_cur.hour) * rpt_alarm_pkg::MINUTES_PER_HOUR) +
                   11'(set_cur.minute);
      now_nxt    = 11'(11'(ctl.now_hour) * rpt_alarm_pkg::MINUTES_PER_HOUR) +
                   11'(ctl.now_minute);
      now_ok_nxt = (ctl.now_hour <= rpt_alarm_pkg::HOUR_MAX) &&
                   (ctl.now_minute <= rpt_alarm_pkg::MINUTE_MAX);
    end else if (busy_r) begin
      if (cnt_r == set_cur.repeats) begin
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
        found_nxt = 1'b0;
      end else if (now_ok_r && (t_r == now_r)) begin
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
        found_nxt = 1'b1;
      end else begin
        cnt_nxt = 7'(cnt_r + 7'd1);
        t_nxt   = (t_sum >= 12'(rpt_alarm_pkg::MINUTES_PER_DAY)) ?
                  11'(t_sum - 12'(rpt_alarm_pkg::MINUTES_PER_DAY)) : 11'(t_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      found_r <= found_nxt;
    end
    now_ok_r <= now_ok_nxt;
    t_r      <= t_nxt;
    now_r    <= now_nxt;
    cnt_r    <= cnt_nxt;
  end

  assign sts.done  = done_r;
  assign sts.found = found_r;

endmodule

### sv/repeating_alarm_with_digit_editor_top.sv
// Top level of the repeating alarm with digit editor: handshake, settings and result register.
//
//  Channel | Direction | Beat contents
//  in_     | slave     | tuser: action; tdata: digit_pos, now_hour, now_minute
//  out_    | master    | tdata: alarm_on, alarm_hour, alarm_minute, repeat_count, interval_minutes
//
// An edit beat writes the new settings on acceptance; its result is registered once the output is free.
// A check beat is answered once the scanner is done; the scanner steps through one
// repetition per cycle and stops at the first match.
// Synchronous active-low reset returns the settings to 00:00, no repeats, interval 1.
// A new beat is accepted while the previous result waits in the output register.
module repeating_alarm_with_digit_editor_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // digit_pos[3:0], now_hour[8:4], now_minute[14:9]
  input  logic [1:0]  in_tuser,  // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata  // alarm_on[0], alarm_hour[5:1], alarm_minute[11:6],
                                 // repeat_count[18:12], interval_minutes[25:19]
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                    state_r,   state_nxt;
  rpt_alarm_pkg::alarm_set_t set_r,     set_nxt;
  logic                      ringing_r, ringing_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [31:0]               out_data_r,  out_data_nxt;

  rpt_alarm_pkg::alarm_set_t edit_set;
  rpt_alarm_pkg::scan_ctl_t  scan_ctl;
  rpt_alarm_pkg::scan_sts_t  scan_sts;
  logic                      in_fire;
  logic                      out_free;
  logic                      is_check;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign is_check  = (in_tuser == rpt_alarm_pkg::ACT_CHECK);

  rpt_alarm_edit u_edit (
    .action    (in_tuser),
    .digit_pos (in_tdata[3:0]),
    .set_cur   (set_r),
    .set_nxt   (edit_set)
  );

  assign scan_ctl.start      = in_fire && is_check;
  assign scan_ctl.now_hour   = in_tdata[8:4];
  assign scan_ctl.now_minute = in_tdata[14:9];

  rpt_alarm_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (scan_ctl),
    .set_cur (set_r),
    .sts     (scan_sts)
  );

  always_comb begin
    state_nxt     = state_r;
    set_nxt       = set_r;
    ringing_nxt   = ringing_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (is_check) begin
            state_nxt = ST_SCAN;
          end else begin
            set_nxt   = edit_set;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (scan_sts.done) begin
          ringing_nxt = scan_sts.found;
          state_nxt   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'd0, set_r.interval, set_r.repeats, set_r.minute,
                           set_r.hour, ringing_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      set_r.hour     <= 5'd0;
      set_r.minute   <= 6'd0;
      set_r.repeats  <= 7'd0;
      set_r.interval <= 7'd1;
      ringing_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      set_r       <= set_nxt;
      ringing_r   <= ringing_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
